// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen high
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/jdd_pkg.sv =====
// ----------------------------------------------------------------------------
// jdd_pkg
// shared constants and types of the joystick differential drive mixer
// ----------------------------------------------------------------------------
package jdd_pkg;

  localparam int SAMPLE_BITS_DEF = 10;

  // normalized magnitude, quotient of the shared divider
  localparam int QUOT_W = 8;
  localparam int DZ_W = 8;
  localparam int TURN_W = 12;
  localparam int PROD_W = QUOT_W + TURN_W;
  localparam int OFF_W = PROD_W - 8;
  // signed mix: fb magnitude plus or minus a 12 bit offset
  localparam int MIX_W = OFF_W + 2;

  localparam logic [QUOT_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [DZ_W-1:0] DEAD_ZONE_RST = 8'd10;
  localparam logic [TURN_W-1:0] TURN_RST = 12'd128;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FB_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LR_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LR_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LR_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TURN = 3'd7;

  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic busy;
    logic last;
  } div_stat_t;

  typedef struct packed {
    logic [QUOT_W-1:0] m1_speed;
    logic m1_reverse;
    logic [QUOT_W-1:0] m2_speed;
    logic m2_reverse;
  } motor_res_t;

endpackage

// ===== rtl/core/jdd_div_unit.sv =====
// ----------------------------------------------------------------------------
// jdd_div_unit
// restoring divider, one quotient bit per cycle, shared by both axes
// ----------------------------------------------------------------------------
module jdd_div_unit #(
  parameter int SAMPLE_BITS = jdd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [SAMPLE_BITS+jdd_pkg::QUOT_W-1:0] dividend,
  input  logic [SAMPLE_BITS-1:0]                 divisor,
  output logic [jdd_pkg::QUOT_W-1:0]             quot,
  output jdd_pkg::div_stat_t                     stat
);

  localparam int QW = jdd_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QW - 1);

  logic [SAMPLE_BITS-1:0] rem_r;
  logic [SAMPLE_BITS-1:0] dvs_r;
  logic [QW-1:0]          low_r;
  logic [QW-1:0]          quot_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r;

  logic [SAMPLE_BITS:0] trial;
  logic [SAMPLE_BITS:0] trial_sub;
  logic                 fits;

  // dividend is known to be below divisor * 2^8, so the upper part starts as remainder
  assign trial     = {rem_r, low_r[QW-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend[SAMPLE_BITS+QW-1:QW];
      low_r  <= dividend[QW-1:0];
      dvs_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      low_r  <= {low_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], fits};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.last = busy_r && (cnt_r == CNT_LAST);

endmodule

// ===== rtl/core/jdd_mixer.sv =====
// ----------------------------------------------------------------------------
// jdd_mixer
// steering offset multiply and clamp of both motor values
// ----------------------------------------------------------------------------
module jdd_mixer (
  input  logic                          clk,
  input  logic                          load,
  input  logic [jdd_pkg::QUOT_W-1:0]    lr_mag,
  input  logic [jdd_pkg::TURN_W-1:0]    turn,
  input  logic [jdd_pkg::QUOT_W-1:0]    fb_mag,
  input  logic                          left,
  input  logic                          backward,
  output jdd_pkg::motor_res_t           res
);

  localparam int QW = jdd_pkg::QUOT_W;
  localparam int MW = jdd_pkg::MIX_W;
  localparam int OW = jdd_pkg::OFF_W;
  localparam int PW = jdd_pkg::PROD_W;

  logic [PW-1:0] prod_r;
  logic [QW-1:0] fbm_r;
  logic          left_r;
  logic          back_r;
  logic          lr_zero_r;

  logic signed [MW-1:0] fb_s;
  logic signed [MW-1:0] off_s;
  logic signed [MW-1:0] mix_a;
  logic signed [MW-1:0] mix_b;
  logic [QW-1:0]        spd_a;
  logic [QW-1:0]        spd_b;
  logic                 flip_a;
  logic                 flip_b;

  // clamp high, negate and saturate low
  function automatic logic [QW:0] finish(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] neg_v;
    logic [QW:0]          r;
    neg_v = -v;
    if (v > $signed({{(MW-QW){1'b0}}, jdd_pkg::FULL_SCALE})) begin
      r = {1'b0, jdd_pkg::FULL_SCALE};
    end else if (v < 0) begin
      if (neg_v > $signed({{(MW-QW){1'b0}}, jdd_pkg::FULL_SCALE})) begin
        r = {1'b1, jdd_pkg::FULL_SCALE};
      end else begin
        r = {1'b1, neg_v[QW-1:0]};
      end
    end else begin
      r = {1'b0, v[QW-1:0]};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r    <= PW'(lr_mag) * PW'(turn);
      fbm_r     <= fb_mag;
      left_r    <= left;
      back_r    <= backward;
      lr_zero_r <= (lr_mag == '0);
    end
  end

  assign fb_s  = $signed({{(MW-QW){1'b0}}, fbm_r});
  assign off_s = $signed({2'b00, prod_r[PW-1:PW-OW]});
  assign mix_a = left_r ? (fb_s - off_s) : (fb_s + off_s);
  assign mix_b = left_r ? (fb_s + off_s) : (fb_s - off_s);

  assign {flip_a, spd_a} = finish(mix_a);
  assign {flip_b, spd_b} = finish(mix_b);

  always_comb begin
    if (lr_zero_r) begin
      res.m1_speed   = fbm_r;
      res.m1_reverse = back_r;
      res.m2_speed   = fbm_r;
      res.m2_reverse = back_r;
    end else begin
      res.m1_speed   = spd_a;
      res.m1_reverse = back_r ^ flip_a;
      res.m2_speed   = spd_b;
      res.m2_reverse = back_r ^ flip_b;
    end
  end

endmodule

// ===== rtl/core/joystick_to_differential_drive_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_to_differential_drive_unit
// joystick axes to two motor speeds and directions
// ----------------------------------------------------------------------------
// Each input word carries one raw front-back and one left-right sample. A word
// goes from acceptance to the result register through a setup and a divide
// step per axis, on the single shared bit-serial divider that scales both
// axes in turn, then the steering multiply, then the clamp and load of the
// result. in_tready is high only while the sequencer is idle; a finished
// result waits in its own register, so the next word may be accepted before
// the last result is taken. Each axis magnitude is (distance from center) *
// 255 / (tracked bound - center), with a zero span giving 0; the tracked
// minimum and maximum widen when a sample passes them and raise the matching
// range flag in that result. Configuration is accepted in every cycle but
// must only be written while the block is idle; writing a low or high limit
// also reloads the tracked bound.
// ----------------------------------------------------------------------------
module joystick_to_differential_drive_unit #(
  parameter int SAMPLE_BITS = jdd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // fields from bit 0: fb_sample, lr_sample, zero fill
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // fields from bit 0: motor1_speed, motor1_reverse, motor2_speed,
  // motor2_reverse, fb_over_range, fb_under_range, lr_over_range,
  // lr_under_range, zero fill
  output logic [jdd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [jdd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [jdd_pkg::CFG_DATA_W-1:0]         cfg_data
);

  localparam int SB = SAMPLE_BITS;
  localparam int QW = jdd_pkg::QUOT_W;
  localparam logic [SB-1:0] CENTER_RST = {1'b1, {(SB-1){1'b0}}};

  // sequencer codes
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SETUP_FB = 3'd1;
  localparam logic [2:0] ST_DIV_FB   = 3'd2;
  localparam logic [2:0] ST_SETUP_LR = 3'd3;
  localparam logic [2:0] ST_DIV_LR   = 3'd4;
  localparam logic [2:0] ST_MIX      = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // configuration registers, the limits live on in the tracked bounds
  logic [SB-1:0]               fb_ctr_r;
  logic [SB-1:0]               lr_ctr_r;
  logic [jdd_pkg::DZ_W-1:0]    dead_zone_r;
  logic [jdd_pkg::TURN_W-1:0]  turn_r;

  // tracked bounds
  logic [SB-1:0] fb_min_r, fb_max_r, lr_min_r, lr_max_r;

  // captured word and per-word status
  logic [SB-1:0] fb_s_r, lr_s_r;
  logic          fo_r, fu_r, lo_r, lu_r;
  logic          neg_r;
  logic          zspan_r;
  logic [QW-1:0] fbm_r;
  logic          back_r;

  // result register
  logic [jdd_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                            out_valid_r;

  logic in_acc;
  logic cfg_acc;
  logic out_load;

  // axis setup, shared by both axes
  logic               ax_lr;
  logic               ax_setup;
  logic [SB-1:0]      ax_s, ax_ctr, ax_mn, ax_mx;
  logic               ax_ge, ax_over, ax_under;
  logic [SB-1:0]      ax_bound, ax_span, ax_diff;
  logic [SB+QW-1:0]   ax_dividend;

  // magnitude from the divider
  logic [QW-1:0] div_quot;
  jdd_pkg::div_stat_t div_stat;
  logic [QW-1:0] q_mag;
  logic          in_dz;
  logic [QW-1:0] mag;
  logic          mag_neg;

  jdd_pkg::motor_res_t mix_res;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // ---- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_SETUP_FB;
      ST_SETUP_FB: state_nxt = ST_DIV_FB;
      ST_DIV_FB:   if (div_stat.last) state_nxt = ST_SETUP_LR;
      ST_SETUP_LR: state_nxt = ST_DIV_LR;
      ST_DIV_LR:   if (div_stat.last) state_nxt = ST_MIX;
      ST_MIX:      state_nxt = ST_DONE;
      ST_DONE:     if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- axis setup: range check, bound widening, span and scaled distance
  assign ax_lr    = (state_r == ST_SETUP_LR);
  assign ax_setup = (state_r == ST_SETUP_FB) || (state_r == ST_SETUP_LR);
  assign ax_s     = ax_lr ? lr_s_r : fb_s_r;
  assign ax_ctr   = ax_lr ? lr_ctr_r : fb_ctr_r;
  assign ax_mn    = ax_lr ? lr_min_r : fb_min_r;
  assign ax_mx    = ax_lr ? lr_max_r : fb_max_r;

  always_comb begin
    ax_ge    = (ax_s >= ax_ctr);
    ax_over  = ax_ge && (ax_s > ax_mx);
    ax_under = !ax_ge && (ax_s < ax_mn);
    if (ax_ge) begin
      // only the maximum is checked at or above center
      ax_bound = ax_over ? ax_s : ax_mx;
      ax_span  = ax_bound - ax_ctr;
      ax_diff  = ax_s - ax_ctr;
    end else begin
      ax_bound = ax_under ? ax_s : ax_mn;
      ax_span  = ax_ctr - ax_bound;
      ax_diff  = ax_ctr - ax_s;
    end
    // distance times 255
    ax_dividend = {ax_diff, {QW{1'b0}}} - {{QW{1'b0}}, ax_diff};
  end

  jdd_div_unit #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ax_setup),
    .dividend (ax_dividend),
    .divisor  (ax_span),
    .quot     (div_quot),
    .stat     (div_stat)
  );

  // zero span gives 0, then the dead zone clears magnitude and sign
  always_comb begin
    q_mag   = zspan_r ? '0 : div_quot;
    in_dz   = (q_mag < dead_zone_r);
    mag     = in_dz ? '0 : q_mag;
    mag_neg = neg_r && !in_dz;
  end

  // ---- configuration, tracked bounds and per-word status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_ctr_r    <= CENTER_RST;
      lr_ctr_r    <= CENTER_RST;
      dead_zone_r <= jdd_pkg::DEAD_ZONE_RST;
      turn_r      <= jdd_pkg::TURN_RST;
      fb_min_r    <= '0;
      fb_max_r    <= '1;
      lr_min_r    <= '0;
      lr_max_r    <= '1;
    end else if (cfg_acc) begin
      case (cfg_index)
        jdd_pkg::REG_FB_CENTER: fb_ctr_r <= cfg_data[SB-1:0];
        jdd_pkg::REG_FB_LOW:    fb_min_r <= cfg_data[SB-1:0];
        jdd_pkg::REG_FB_HIGH:   fb_max_r <= cfg_data[SB-1:0];
        jdd_pkg::REG_LR_CENTER: lr_ctr_r <= cfg_data[SB-1:0];
        jdd_pkg::REG_LR_LOW:    lr_min_r <= cfg_data[SB-1:0];
        jdd_pkg::REG_LR_HIGH:   lr_max_r <= cfg_data[SB-1:0];
        jdd_pkg::REG_DEAD_ZONE: dead_zone_r <= cfg_data[jdd_pkg::DZ_W-1:0];
        jdd_pkg::REG_TURN:      turn_r <= cfg_data[jdd_pkg::TURN_W-1:0];
        default: ;
      endcase
    end else if (ax_setup) begin
      // widen the bound on the sample's side of the center
      if (ax_lr) begin
        if (ax_over)  lr_max_r <= ax_s;
        if (ax_under) lr_min_r <= ax_s;
      end else begin
        if (ax_over)  fb_max_r <= ax_s;
        if (ax_under) fb_min_r <= ax_s;
      end
    end
  end

  // payload: captured samples, flags and intermediate magnitudes
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fb_s_r <= in_tdata[SB-1:0];
      lr_s_r <= in_tdata[2*SB-1:SB];
    end
    if (ax_setup) begin
      neg_r   <= !ax_ge;
      zspan_r <= (ax_span == '0);
      if (ax_lr) begin
        lo_r   <= ax_over;
        lu_r   <= ax_under;
        // fb quotient is still in the divider here
        fbm_r  <= mag;
        back_r <= mag_neg;
      end else begin
        fo_r <= ax_over;
        fu_r <= ax_under;
      end
    end
  end

  // lr magnitude goes straight into the multiply in the mix cycle
  jdd_mixer u_mix (
    .clk      (clk),
    .load     (state_r == ST_MIX),
    .lr_mag   (mag),
    .turn     (turn_r),
    .fb_mag   (fbm_r),
    .left     (mag_neg),
    .backward (back_r),
    .res      (mix_res)
  );

  // ---- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {2'b00, lu_r, lo_r, fu_r, fo_r,
                     mix_res.m2_reverse, mix_res.m2_speed,
                     mix_res.m1_reverse, mix_res.m1_speed};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/jdd_checker.sv =====
// ----------------------------------------------------------------------------
// jdd_checker
// port level checks of the joystick differential drive mixer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jdd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [jdd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready
);

  // a held result word keeps its value
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")

  // one word at a time: busy right after accepting
  `ASSERT_CLK(a_busy_after_acc, in_tvalid && in_tready |=> !in_tready, "input ready right after accept")

  // a new result is loaded only from the busy sequencer
  `ASSERT_CLK(a_load_from_busy, $rose(out_tvalid) |-> !$past(in_tready), "result appeared while idle")

  // a sample lies on one side of the center only
  `ASSERT_NEVER(a_fb_flags, out_tvalid && out_tdata[18] && out_tdata[19], "fb over and under both set")
  `ASSERT_NEVER(a_lr_flags, out_tvalid && out_tdata[20] && out_tdata[21], "lr over and under both set")

endmodule

bind joystick_to_differential_drive_unit jdd_checker u_jdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// joystick_to_differential_drive_unit: scaling, range tracking and motor mix
// ----------------------------------------------------------------------------
// A queue of sample pairs feeds a clocked driver. Each word that the block
// accepts is run through a model of the mixer kept here, and the predicted
// drive word waits in a queue. A clocked monitor compares every result word
// field by field with the oldest prediction. Register settings change only
// while the block is idle: first a few fixed setups with hand-picked samples
// for the edge cases, then random setups with random samples, under three
// idling patterns and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SB = jdd_pkg::SAMPLE_BITS_DEF;
  localparam int IN_W = ((2 * SB + 7) / 8) * 8;
  localparam int MAX_CYCLES = 400000;
  // margin for the block to finish its last word
  localparam int SETTLE = 30;
  localparam int RANDOM_SETUPS = 12;
  localparam int SETUP_WORDS = 75;
  localparam int HOLD_CYCLES = 400;

  typedef logic [SB-1:0] sample_t;
  typedef logic [jdd_pkg::DZ_W-1:0] dz_t;
  typedef logic [jdd_pkg::TURN_W-1:0] turn_t;
  typedef logic [jdd_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [jdd_pkg::CFG_DATA_W-1:0] cfg_word_t;

  // result word layout, motor 1 speed in the lowest bits
  typedef struct packed {
    logic          lr_under;
    logic          lr_over;
    logic          fb_under;
    logic          fb_over;
    logic          m2_rev;
    logic [7:0]    m2_speed;
    logic          m1_rev;
    logic [7:0]    m1_speed;
  } drive_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  // fields from bit 0: fb_sample, lr_sample, zero fill
  logic [IN_W-1:0]        in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // fields from bit 0: motor1_speed, motor1_reverse, motor2_speed,
  // motor2_reverse, fb_over_range, fb_under_range, lr_over_range,
  // lr_under_range, zero fill
  logic [jdd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = '0;
  cfg_word_t              cfg_data = '0;

  joystick_to_differential_drive_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // mirror of the register file and the tracked bounds
  sample_t           fb_ctr, lr_ctr;
  sample_t           fb_min, fb_max, lr_min, lr_max;
  dz_t               dz;
  turn_t             turn;

  logic [IN_W-1:0]   pending_samples[$];
  drive_word_t       expected_drive[$];

  int words_queued = 0;
  int words_accepted = 0;
  int words_checked = 0;
  int regs_written = 0;
  int errors = 0;
  int cycle_count = 0;
  int flag_hits[4] = '{0, 0, 0, 0};
  int reversed_seen = 0;

  // idling in percent, set by the sequence below
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_armed = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // mixer model
  // --------------------------------------------------------------------------

  function automatic void reset_model();
    fb_ctr = 10'd512;
    lr_ctr = 10'd512;
    fb_min = '0;
    fb_max = '1;
    lr_min = '0;
    lr_max = '1;
    dz = jdd_pkg::DEAD_ZONE_RST;
    turn = jdd_pkg::TURN_RST;
  endfunction

  // limit registers go straight into the tracked bounds
  function automatic void apply_reg(input cfg_idx_t idx, input cfg_word_t d);
    case (idx)
      jdd_pkg::REG_FB_CENTER: fb_ctr = d[SB-1:0];
      jdd_pkg::REG_FB_LOW:    fb_min = d[SB-1:0];
      jdd_pkg::REG_FB_HIGH:   fb_max = d[SB-1:0];
      jdd_pkg::REG_LR_CENTER: lr_ctr = d[SB-1:0];
      jdd_pkg::REG_LR_LOW:    lr_min = d[SB-1:0];
      jdd_pkg::REG_LR_HIGH:   lr_max = d[SB-1:0];
      jdd_pkg::REG_DEAD_ZONE: dz = d[jdd_pkg::DZ_W-1:0];
      jdd_pkg::REG_TURN:      turn = d[jdd_pkg::TURN_W-1:0];
      default: ;
    endcase
  endfunction

  // one axis to magnitude and sign; only the bound on the sample's side of
  // center is checked and widened
  function automatic logic [7:0] scale_axis(input sample_t s, input sample_t ctr,
                                            inout sample_t mn, inout sample_t mx,
                                            output logic neg, output logic over,
                                            output logic under);
    int unsigned span;
    int unsigned mag;
    over = 1'b0;
    under = 1'b0;
    if (s >= ctr) begin
      if (s > mx) begin
        mx = s;
        over = 1'b1;
      end
      span = mx - ctr;
      mag = (span == 0) ? 0 : ((s - ctr) * 255) / span;
      neg = 1'b0;
    end else begin
      if (s < mn) begin
        mn = s;
        under = 1'b1;
      end
      span = ctr - mn;
      mag = (span == 0) ? 0 : ((ctr - s) * 255) / span;
      neg = 1'b1;
    end
    if (mag > 255) mag = 255;
    if (mag < dz) begin
      mag = 0;
      neg = 1'b0;
    end
    return mag[7:0];
  endfunction

  // clamp at full scale; a negative mix flips direction and saturates
  function automatic logic [7:0] motor_limit(input int v, inout logic rev);
    if (v > 255) return 8'd255;
    if (v < 0) begin
      rev = ~rev;
      v = -v;
      if (v > 255) v = 255;
    end
    return v[7:0];
  endfunction

  function automatic drive_word_t mix_drive(input sample_t fb_s, input sample_t lr_s);
    drive_word_t w;
    logic [7:0] fbm, lrm;
    logic back, left, fo, fu, lo, lu, r1, r2;
    int off, a, b;
    fbm = scale_axis(fb_s, fb_ctr, fb_min, fb_max, back, fo, fu);
    lrm = scale_axis(lr_s, lr_ctr, lr_min, lr_max, left, lo, lu);
    r1 = back;
    r2 = back;
    if (lrm == 0) begin
      w.m1_speed = fbm;
      w.m2_speed = fbm;
    end else begin
      off = (int'(lrm) * int'(turn)) >> 8;
      // right steering speeds up motor 1, left steering motor 2
      a = left ? int'(fbm) - off : int'(fbm) + off;
      b = left ? int'(fbm) + off : int'(fbm) - off;
      w.m1_speed = motor_limit(a, r1);
      w.m2_speed = motor_limit(b, r2);
    end
    w.m1_rev = r1;
    w.m2_rev = r2;
    w.fb_over = fo;
    w.fb_under = fu;
    w.lr_over = lo;
    w.lr_under = lu;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers queued sample words, predicts on acceptance
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_drive.push_back(mix_drive(in_tdata[SB-1:0], in_tdata[2*SB-1:SB]));
        words_accepted++;
      end
      // a new word only once the current one is gone
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks result words, randomizes out_tready
  // --------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [7:0] exp,
                               input logic [7:0] act);
    if (act !== exp) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      errors++;
    end
  endtask

  task automatic check_drive(input drive_word_t exp, input drive_word_t act);
    compare_field("motor1_speed", exp.m1_speed, act.m1_speed);
    compare_field("motor1_reverse", 8'(exp.m1_rev), 8'(act.m1_rev));
    compare_field("motor2_speed", exp.m2_speed, act.m2_speed);
    compare_field("motor2_reverse", 8'(exp.m2_rev), 8'(act.m2_rev));
    compare_field("fb_over_range", 8'(exp.fb_over), 8'(act.fb_over));
    compare_field("fb_under_range", 8'(exp.fb_under), 8'(act.fb_under));
    compare_field("lr_over_range", 8'(exp.lr_over), 8'(act.lr_over));
    compare_field("lr_under_range", 8'(exp.lr_under), 8'(act.lr_under));
    words_checked++;
    flag_hits[0] += int'(exp.fb_over);
    flag_hits[1] += int'(exp.fb_under);
    flag_hits[2] += int'(exp.lr_over);
    flag_hits[3] += int'(exp.lr_under);
    reversed_seen += int'(exp.m1_rev ^ exp.m2_rev);
  endtask

  // one long stall so the result register fills and in_tready drops
  always @(posedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_drive.size() == 0) begin
          $error("drive word %h with no sample waiting", out_tdata);
          errors++;
        end else begin
          check_drive(expected_drive.pop_front(),
                      drive_word_t'(out_tdata[$bits(drive_word_t)-1:0]));
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  // random bits above the register width, which the block must drop
  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_word_t d;
    d = cfg_word_t'($urandom);
    case (idx)
      jdd_pkg::REG_DEAD_ZONE: d[jdd_pkg::DZ_W-1:0] = dz_t'(val);
      jdd_pkg::REG_TURN:      d[jdd_pkg::TURN_W-1:0] = turn_t'(val);
      default:                d[SB-1:0] = sample_t'(val);
    endcase
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    regs_written++;
  endtask

  function automatic int unsigned pick_value(input int unsigned top);
    case ($urandom_range(7))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(top);
    endcase
  endfunction

  task automatic write_random_setup();
    write_reg(jdd_pkg::REG_FB_CENTER, pick_value(1023));
    write_reg(jdd_pkg::REG_FB_LOW, pick_value(1023));
    write_reg(jdd_pkg::REG_FB_HIGH, pick_value(1023));
    write_reg(jdd_pkg::REG_LR_CENTER, pick_value(1023));
    write_reg(jdd_pkg::REG_LR_LOW, pick_value(1023));
    write_reg(jdd_pkg::REG_LR_HIGH, pick_value(1023));
    // mostly a narrow dead zone so that the mix stays busy
    write_reg(jdd_pkg::REG_DEAD_ZONE,
              $urandom_range(1) ? pick_value(255) : $urandom_range(24));
    write_reg(jdd_pkg::REG_TURN, pick_value(4095));
    cfg_valid <= 1'b0;
  endtask

  // uniform, near center, exact center or an end of the scale
  function automatic sample_t pick_sample(input sample_t ctr);
    int v;
    case ($urandom_range(9))
      5, 6:    v = int'(ctr) + int'($urandom_range(80)) - 40;
      7:       v = $urandom_range(1) ? 1023 : 0;
      8:       v = int'(ctr);
      default: v = int'($urandom_range(1023));
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return sample_t'(v);
  endfunction

  task automatic queue_sample(input sample_t fb, input sample_t lr);
    pending_samples.push_back(IN_W'({lr, fb}));
    words_queued++;
  endtask

  // every accepted word answered, then the block's latency on top
  task automatic wait_idle();
    while (words_accepted != words_queued || expected_drive.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  initial begin
    reset_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(30, 80);

    // reset setup: center, full travel, corners, dead zone edge
    queue_sample(10'd512, 10'd512);
    queue_sample(10'd1023, 10'd512);
    queue_sample(10'd0, 10'd512);
    queue_sample(10'd512, 10'd1023);
    queue_sample(10'd512, 10'd0);
    queue_sample(10'd1023, 10'd1023);
    queue_sample(10'd0, 10'd0);
    queue_sample(10'd1023, 10'd0);
    queue_sample(10'd0, 10'd1023);
    queue_sample(10'd532, 10'd512);
    queue_sample(10'd533, 10'd491);
    queue_sample(10'd768, 10'd300);
    wait_idle();

    // narrowed bounds to widen, no dead zone, maximum turn gain
    write_reg(jdd_pkg::REG_FB_HIGH, 800);
    write_reg(jdd_pkg::REG_FB_LOW, 200);
    write_reg(jdd_pkg::REG_LR_HIGH, 600);
    write_reg(jdd_pkg::REG_LR_LOW, 400);
    write_reg(jdd_pkg::REG_DEAD_ZONE, 0);
    write_reg(jdd_pkg::REG_TURN, 4095);
    cfg_valid <= 1'b0;
    queue_sample(10'd900, 10'd700);
    queue_sample(10'd850, 10'd650);
    queue_sample(10'd100, 10'd300);
    queue_sample(10'd0, 10'd1023);
    queue_sample(10'd1023, 10'd512);
    wait_idle();

    // zero span, minimum above center, widest dead zone, no steering gain
    write_reg(jdd_pkg::REG_FB_CENTER, 512);
    write_reg(jdd_pkg::REG_FB_HIGH, 512);
    write_reg(jdd_pkg::REG_FB_LOW, 700);
    write_reg(jdd_pkg::REG_LR_CENTER, 1023);
    write_reg(jdd_pkg::REG_LR_HIGH, 1023);
    write_reg(jdd_pkg::REG_DEAD_ZONE, 255);
    write_reg(jdd_pkg::REG_TURN, 0);
    cfg_valid <= 1'b0;
    queue_sample(10'd512, 10'd1023);
    queue_sample(10'd600, 10'd1023);
    queue_sample(10'd300, 10'd0);
    queue_sample(10'd513, 10'd512);
    wait_idle();

    // random setups, idling pattern switched twice along the way
    for (int p = 0; p < RANDOM_SETUPS; p++) begin
      if (p == 4) set_idling(80, 30);
      if (p == 8) set_idling(0, 0);
      write_random_setup();
      for (int i = 0; i < SETUP_WORDS; i++)
        queue_sample(pick_sample(fb_ctr), pick_sample(lr_ctr));
      if (p == 10) hold_armed <= 1'b1;
      wait_idle();
    end

    $display("%0d drive words checked across %0d register writes, incl. one %0d cycle stall",
             words_checked, regs_written, HOLD_CYCLES);
    $display("bounds widened: fb over %0d, fb under %0d, lr over %0d, lr under %0d; %0d spins",
             flag_hits[0], flag_hits[1], flag_hits[2], flag_hits[3], reversed_seen);
    if (errors == 0 && expected_drive.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
